// ===== sv/blg_pkg.sv =====
package blg_pkg;

	// field and register widths
	localparam int NOW_W      = 32;
	localparam int MV_W       = 14;
	localparam int INTERVAL_W = 16;
	localparam int LEVEL_W    = 8;
	localparam int SMOOTH_W   = 18;
	localparam int FRAC_SHIFT = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	typedef logic [SMOOTH_W-1:0]       smooth_t;
	typedef logic signed [LEVEL_W-1:0] level_t;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_UPDATE_INTERVAL = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_VALID       = 2'd1;

	localparam logic [INTERVAL_W-1:0] INTERVAL_RST  = 16'd2000;
	localparam logic [MV_W-1:0]       MIN_VALID_RST = 14'd500;

	// EWMA: (7*old + 48*mv + 5) / 10, divide done as multiply by ceil(2^26/10)
	localparam int EWMA_W      = 22;
	localparam int RECIP10_W   = 23;
	localparam int DIV10_SHIFT = 26;
	localparam logic [RECIP10_W-1:0] RECIP10 = 23'd6710887;

	// curve, voltages in 1/16 mV
	localparam int SEGS      = 8;
	localparam int SEG_IDX_W = 3;
	localparam int NUM_W     = 17;
	localparam int RECIP_W   = 21;
	localparam int CURVE_SHIFT = 31;
	localparam int PCT_W     = 7;

	localparam smooth_t CURVE_FLOOR = 18'd52800;
	localparam smooth_t CURVE_TOP   = 18'd67200;

	localparam level_t LEVEL_INVALID = -8'sd1;
	localparam level_t LEVEL_EMPTY   = 8'sd0;
	localparam level_t LEVEL_FULL    = 8'sd100;

	localparam smooth_t SEG_LO [SEGS] = '{
		18'd52800, 18'd56000, 18'd57600, 18'd59200,
		18'd60000, 18'd61600, 18'd63200, 18'd64800};
	localparam smooth_t SEG_HI [SEGS] = '{
		18'd56000, 18'd57600, 18'd59200, 18'd60000,
		18'd61600, 18'd63200, 18'd64800, 18'd67200};
	localparam logic [11:0] SEG_DEN [SEGS] = '{
		12'd3200, 12'd1600, 12'd1600, 12'd800,
		12'd1600, 12'd1600, 12'd1600, 12'd2400};
	localparam logic [3:0] SEG_DP [SEGS] = '{
		4'd10, 4'd10, 4'd15, 4'd15, 4'd15, 4'd15, 4'd12, 4'd8};
	localparam logic [PCT_W-1:0] SEG_BASE [SEGS] = '{
		7'd0, 7'd10, 7'd20, 7'd35, 7'd50, 7'd65, 7'd80, 7'd92};
	// ceil(2^31 / (2*den)); exact floor for numerators below 2^17
	localparam logic [RECIP_W-1:0] SEG_RECIP [SEGS] = '{
		21'd335545, 21'd671089, 21'd671089, 21'd1342178,
		21'd671089, 21'd671089, 21'd671089, 21'd447393};

endpackage

// ===== sv/blg_if.sv =====
interface blg_poll_if;
	logic                        valid;
	logic                        ready;
	logic [blg_pkg::NOW_W-1:0]   now_ms;
	logic [blg_pkg::MV_W-1:0]    sample_mv;

	modport source (output valid, now_ms, sample_mv, input ready);
	modport sink (input valid, now_ms, sample_mv, output ready);
endinterface

interface blg_level_if;
	logic                  valid;
	logic                  ready;
	blg_pkg::level_t       level;

	modport source (output valid, level, input ready);
	modport sink (input valid, level, output ready);
endinterface

// ===== sv/blg_front.sv =====
module blg_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [blg_pkg::INTERVAL_W-1:0] interval,
	blg_poll_if.sink                       poll,
	output logic                           push_valid,
	input  logic                           push_ready,
	output blg_pkg::smooth_t               push_data
);
	import blg_pkg::*;

	smooth_t                 smoothed_q;
	logic [NOW_W-1:0]        last_q;
	logic                    seeded_q;

	logic                    accept;
	logic [NOW_W-1:0]        elapsed;
	logic                    due;
	logic [EWMA_W-1:0]       sum;
	logic [EWMA_W+RECIP10_W-1:0] prod;
	smooth_t                 ewma;
	smooth_t                 next_smoothed;

	assign poll.ready = push_ready;
	assign accept     = poll.valid && push_ready;

	// wrap-safe elapsed time
	assign elapsed = poll.now_ms - last_q;
	assign due     = elapsed >= {{(NOW_W-INTERVAL_W){1'b0}}, interval};

	// 7*old + 48*new + 5
	assign sum = ({{(EWMA_W-SMOOTH_W){1'b0}}, smoothed_q} << 3)
		- {{(EWMA_W-SMOOTH_W){1'b0}}, smoothed_q}
		+ ({{(EWMA_W-MV_W){1'b0}}, poll.sample_mv} << 5)
		+ ({{(EWMA_W-MV_W){1'b0}}, poll.sample_mv} << 4)
		+ EWMA_W'(5);
	assign prod = {{RECIP10_W{1'b0}}, sum} * {{EWMA_W{1'b0}}, RECIP10};
	assign ewma = prod[DIV10_SHIFT +: SMOOTH_W];

	always_comb begin
		if (!seeded_q) begin
			next_smoothed = {poll.sample_mv, {FRAC_SHIFT{1'b0}}};
		end else if (due) begin
			next_smoothed = ewma;
		end else begin
			next_smoothed = smoothed_q;
		end
	end

	assign push_valid = poll.valid;
	assign push_data  = next_smoothed;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smoothed_q <= '0;
			last_q     <= '0;
			seeded_q   <= 1'b0;
		end else if (accept) begin
			smoothed_q <= next_smoothed;
			seeded_q   <= 1'b1;
			if (!seeded_q || due) begin
				last_q <= poll.now_ms;
			end
		end
	end
endmodule

// ===== sv/blg_queue.sv =====
module blg_queue #(
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  blg_pkg::smooth_t push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output blg_pkg::smooth_t pop_data
);
	import blg_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	smooth_t           mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = count_q != CNT_W'(DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end
endmodule

// ===== sv/blg_back.sv =====
module blg_back (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [blg_pkg::MV_W-1:0] min_valid,
	input  logic                     pop_valid,
	output logic                     pop_ready,
	input  blg_pkg::smooth_t         pop_data,
	blg_level_if.source              result
);
	import blg_pkg::*;

	// stage 1: validity, clamp, segment pick, numerator
	logic                    v_s1;
	logic                    interp_s1;
	level_t                  fixed_s1;
	logic [SEG_IDX_W-1:0]    seg_s1;
	logic [NUM_W-1:0]        num_s1;

	// stage 2: output word
	logic                    v_s2;
	level_t                  level_s2;

	logic                    adv_s1;
	logic                    adv_s2;
	logic                    invalid;
	logic                    below;
	logic                    above;
	logic [SEG_IDX_W-1:0]    seg;
	smooth_t                 diff;
	logic [NUM_W-1:0]        scaled;
	logic [NUM_W-1:0]        num;
	level_t                  fixed;
	logic [NUM_W+RECIP_W-1:0] prod;
	logic [PCT_W-1:0]        frac;
	logic [PCT_W-1:0]        pct;

	assign adv_s2    = !v_s2 || result.ready;
	assign adv_s1    = !v_s1 || adv_s2;
	assign pop_ready = adv_s1;

	assign invalid = pop_data <= {min_valid, {FRAC_SHIFT{1'b0}}};
	assign below   = pop_data <= CURVE_FLOOR;
	assign above   = pop_data >= CURVE_TOP;

	always_comb begin
		seg = SEG_IDX_W'(SEGS - 1);
		for (int k = SEGS - 1; k >= 0; k--) begin
			if (pop_data < SEG_HI[k]) begin
				seg = SEG_IDX_W'(k);
			end
		end
	end

	// 2*(s - lo)*dp + den, offset below 3200 so 12 bits suffice
	assign diff   = pop_data - SEG_LO[seg];
	assign scaled = {{(NUM_W-12){1'b0}}, diff[11:0]} * {{(NUM_W-4){1'b0}}, SEG_DP[seg]};
	assign num    = {scaled[NUM_W-2:0], 1'b0} + {{(NUM_W-12){1'b0}}, SEG_DEN[seg]};

	always_comb begin
		if (invalid) begin
			fixed = LEVEL_INVALID;
		end else if (below) begin
			fixed = LEVEL_EMPTY;
		end else begin
			fixed = LEVEL_FULL;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			interp_s1 <= !invalid && !below && !above;
			fixed_s1  <= fixed;
			seg_s1    <= seg;
			num_s1    <= num;
		end
	end

	// num / (2*den) by reciprocal multiply
	assign prod = {{RECIP_W{1'b0}}, num_s1} * {{NUM_W{1'b0}}, SEG_RECIP[seg_s1]};
	assign frac = prod[CURVE_SHIFT +: PCT_W];
	assign pct  = SEG_BASE[seg_s1] + frac;

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			level_s2 <= interp_s1 ? level_t'({1'b0, pct}) : fixed_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				v_s1 <= pop_valid;
			end
			if (adv_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	assign result.valid = v_s2;
	assign result.level = level_s2;
endmodule

// ===== sv/battery_level_gauge.sv =====
// Single-cell LiPo charge gauge. Each poll word carries a millisecond timestamp
// and a cell voltage in mV; each poll returns one level word: percent 0..100
// read off a 9-point piecewise-linear curve (3.30 V empty, 4.20 V full, rounded
// to nearest), or -1 when the smoothed voltage is at or below min_valid_mv.
// The first poll after reset seeds the smoothed voltage; later polls blend
// 0.7 old + 0.3 new (1/16 mV fixed point, round to nearest) only once
// update_interval_ms has passed since the last update, elapsed time taken
// modulo 2^32. Throughput is one poll per clock while the queue has room, set by
// the smoothing update in the front end (one constant multiply for the divide by
// ten), which every poll must finish before the next can use its result.
// A level word passes through the queue, then back-end stage 1 and stage 2, before
// it is valid; the queue and two back-end stages absorb output stalls, and
// the poll side sees ready drop only when the queue fills. Write the config
// registers (index 0: update_interval_ms, index 1: min_valid_mv) only while no
// poll is in flight.
module battery_level_gauge #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [blg_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [blg_pkg::CFG_DATA_W-1:0] cfg_wdata,
	blg_poll_if.sink                       poll,
	blg_level_if.source                    result
);
	import blg_pkg::*;

	// config registers
	logic [INTERVAL_W-1:0] interval_q;
	logic [MV_W-1:0]       min_valid_q;

	// front -> queue -> back
	logic    push_valid;
	logic    push_ready;
	smooth_t push_data;
	logic    pop_valid;
	logic    pop_ready;
	smooth_t pop_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q  <= INTERVAL_RST;
			min_valid_q <= MIN_VALID_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_UPDATE_INTERVAL: interval_q  <= cfg_wdata[INTERVAL_W-1:0];
				REG_MIN_VALID:       min_valid_q <= cfg_wdata[MV_W-1:0];
				default: ;
			endcase
		end
	end

	// front: take polls, run the seed / EWMA update, hand smoothed value on
	blg_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.interval   (interval_q),
		.poll       (poll),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	// short queue decouples the poll side from output stalls
	blg_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	// back: validity check and curve lookup, two stages
	blg_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.min_valid (min_valid_q),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.result    (result)
	);
endmodule
